[rtl/core/ray_sphere_intersect_assert.svh]
// Assertion macros for the ray/sphere block.
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// Checked outside reset only.
`define RSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define RSI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/core/rsi_pkg.sv]
`default_nettype none
package rsi_pkg;

    localparam int CW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 31;
    localparam int EW        = 16;
    localparam int NW        = 65 + FRAC_BITS;
    localparam int SQ_STEPS  = 64;
    localparam int DV_STEPS  = DW;
    localparam int Q_DEPTH   = 4;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_MIN_DIST = 3'd4;

    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [DW-1:0] T_MAX = {DW{1'b1}};

    typedef struct packed {
        logic               miss;
        logic               hpos;
        logic [63:0]        mh;
        logic [63:0]        a;
        logic [2:0][CW-1:0] org;
        logic [2:0][CW-1:0] dir;
    } rsi_ray_t;

    typedef struct packed {
        logic [127:0] disc;
        rsi_ray_t     ray;
    } rsi_item_t;

endpackage
`default_nettype wire

[rtl/core/ray_sphere_intersect.sv]
// Ray / sphere intersection, signed Q16.16 fixed point.
// s_ channel: one ray per item; s_tdata holds origin x, y, z then direction
// x, y, z, 32 bits each, lowest bits first.
// m_ channel: one result per ray; m_tuser is the hit flag, m_tdata holds
// hit_x, hit_y, hit_z (32 bits each) and hit_distance (31 bits). A miss
// gives all zeros.
// cfg channel: index 0..2 sphere centre x/y/z, 3 radius, 4 minimum distance;
// other indexes are dropped. Write only while no item is in flight.
// Throughput: one ray per cycle while m_tready does not hold the output. The path
// runs through the 8-stage coefficient front end, the queue, the 64-stage square
// root and the two 31-stage dividers.
// A 4-entry queue sits between the front end and the root pipeline; when
// m_tready is low while a result waits on m_, the root pipeline holds, the
// queue fills, then s_tready falls.
// aresetn (synchronous, active low) empties all stages and the queue and
// loads the register defaults: centre 0, radius 1.0, minimum distance 66.
`default_nettype none
module ray_sphere_intersect import rsi_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // hit_x, hit_y, hit_z, hit_distance, pad
    output logic              m_tuser,   // hit
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    logic [2:0][CW-1:0] center_reg;
    logic [DW-1:0]      radius_reg;
    logic [EW-1:0]      min_dist_reg;

    logic               q_push, q_pop, q_full, q_empty;
    rsi_item_t          q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg   <= '0;
            radius_reg   <= DW'(65536);
            min_dist_reg <= EW'(66);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_data[CW-1:0];
                REG_CENTER_Y: center_reg[1] <= cfg_data[CW-1:0];
                REG_CENTER_Z: center_reg[2] <= cfg_data[CW-1:0];
                REG_RADIUS:   radius_reg    <= cfg_data[DW-1:0];
                REG_MIN_DIST: min_dist_reg  <= cfg_data[EW-1:0];
                default: ;
            endcase
        end
    end

    rsi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .center   (center_reg),
        .radius   (radius_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    rsi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rsi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .min_dist (min_dist_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

[rtl/core/rsi_front.sv]
`default_nettype none
module rsi_front import rsi_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [191:0]       s_tdata,
    input  wire logic [2:0][CW-1:0] center,
    input  wire logic [DW-1:0]      radius,
    input  wire logic               q_full,
    output logic                    q_push,
    output rsi_item_t               q_item
);

    logic                en;
    logic [7:0]          vld_reg;

    logic [2:0][CW-1:0]  org_reg [0:7];
    logic [2:0][CW-1:0]  dir_reg [0:7];
    logic [2:0][CW-1:0]  in_org, in_dir, oc_sat;
    logic [2:0][CW:0]    diff;

    logic [2:0][CW-1:0]  oc0_reg;
    logic [2:0][CW-1:0]  dm1_reg, om1_reg;
    logic [2:0]          sg1_reg, sg2_reg;
    logic [2:0][63:0]    dd2_reg, do2_reg, oo2_reg;
    logic [61:0]         r2_2_reg, r2_3_reg;
    logic [63:0]         a3_reg, hp3_reg, hn3_reg, so3_reg;
    logic [63:0]         a4_reg, mh4_reg, kmag4_reg;
    logic                hpos4_reg, kneg4_reg, zero4_reg;
    logic [63:0]         a5_reg, mh5_reg;
    logic                hpos5_reg, kneg5_reg, zero5_reg;
    logic [3:0][63:0]    ph5_reg, pk5_reg;
    logic [63:0]         a6_reg, mh6_reg;
    logic                hpos6_reg, kneg6_reg, zero6_reg;
    logic [127:0]        h2_6_reg, ak6_reg;
    logic [63:0]         a7_reg, mh7_reg;
    logic                hpos7_reg, miss7_reg;
    logic [127:0]        disc7_reg;

    logic [63:0]         hp_sum, hn_sum;

    assign en       = !q_full || !vld_reg[7];
    assign s_tready = en;
    assign q_push   = vld_reg[7] && !q_full;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_org[i] = s_tdata[CW*i +: CW];
            in_dir[i] = s_tdata[3*CW + CW*i +: CW];
            diff[i]   = {in_org[i][CW-1], in_org[i]} - {center[i][CW-1], center[i]};
            if (diff[i][CW] != diff[i][CW-1]) begin
                oc_sat[i] = diff[i][CW] ? C_MIN : C_MAX;
            end else begin
                oc_sat[i] = diff[i][CW-1:0];
            end
        end
        hp_sum = '0;
        hn_sum = '0;
        for (int i = 0; i < 3; i++) begin
            if (sg2_reg[i]) begin
                hn_sum = hn_sum + do2_reg[i];
            end else begin
                hp_sum = hp_sum + do2_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[6:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            org_reg[0] <= in_org;
            dir_reg[0] <= in_dir;
            for (int k = 1; k < 8; k++) begin
                org_reg[k] <= org_reg[k-1];
                dir_reg[k] <= dir_reg[k-1];
            end
            oc0_reg <= oc_sat;

            for (int i = 0; i < 3; i++) begin
                dm1_reg[i] <= dir_reg[0][i][CW-1] ? ~dir_reg[0][i] + 1'b1 : dir_reg[0][i];
                om1_reg[i] <= oc0_reg[i][CW-1] ? ~oc0_reg[i] + 1'b1 : oc0_reg[i];
                sg1_reg[i] <= dir_reg[0][i][CW-1] ^ oc0_reg[i][CW-1];
            end

            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= 64'(dm1_reg[i]) * 64'(dm1_reg[i]);
                do2_reg[i] <= 64'(dm1_reg[i]) * 64'(om1_reg[i]);
                oo2_reg[i] <= 64'(om1_reg[i]) * 64'(om1_reg[i]);
            end
            sg2_reg  <= sg1_reg;
            r2_2_reg <= 62'(radius) * 62'(radius);

            a3_reg   <= dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
            so3_reg  <= oo2_reg[0] + oo2_reg[1] + oo2_reg[2];
            hp3_reg  <= hp_sum;
            hn3_reg  <= hn_sum;
            r2_3_reg <= r2_2_reg;

            a4_reg    <= a3_reg;
            hpos4_reg <= hp3_reg > hn3_reg;
            mh4_reg   <= (hp3_reg > hn3_reg) ? hp3_reg - hn3_reg : hn3_reg - hp3_reg;
            kneg4_reg <= so3_reg < 64'(r2_3_reg);
            kmag4_reg <= (so3_reg < 64'(r2_3_reg)) ? 64'(r2_3_reg) - so3_reg
                                                   : so3_reg - 64'(r2_3_reg);
            zero4_reg <= a3_reg == '0;

            a5_reg     <= a4_reg;
            mh5_reg    <= mh4_reg;
            hpos5_reg  <= hpos4_reg;
            kneg5_reg  <= kneg4_reg;
            zero5_reg  <= zero4_reg;
            ph5_reg[0] <= 64'(mh4_reg[31:0])  * 64'(mh4_reg[31:0]);
            ph5_reg[1] <= 64'(mh4_reg[31:0])  * 64'(mh4_reg[63:32]);
            ph5_reg[2] <= 64'(mh4_reg[63:32]) * 64'(mh4_reg[31:0]);
            ph5_reg[3] <= 64'(mh4_reg[63:32]) * 64'(mh4_reg[63:32]);
            pk5_reg[0] <= 64'(a4_reg[31:0])  * 64'(kmag4_reg[31:0]);
            pk5_reg[1] <= 64'(a4_reg[31:0])  * 64'(kmag4_reg[63:32]);
            pk5_reg[2] <= 64'(a4_reg[63:32]) * 64'(kmag4_reg[31:0]);
            pk5_reg[3] <= 64'(a4_reg[63:32]) * 64'(kmag4_reg[63:32]);

            a6_reg    <= a5_reg;
            mh6_reg   <= mh5_reg;
            hpos6_reg <= hpos5_reg;
            kneg6_reg <= kneg5_reg;
            zero6_reg <= zero5_reg;
            h2_6_reg  <= {ph5_reg[3], ph5_reg[0]} + {32'd0, ph5_reg[1], 32'd0}
                         + {32'd0, ph5_reg[2], 32'd0};
            ak6_reg   <= {pk5_reg[3], pk5_reg[0]} + {32'd0, pk5_reg[1], 32'd0}
                         + {32'd0, pk5_reg[2], 32'd0};

            a7_reg    <= a6_reg;
            mh7_reg   <= mh6_reg;
            hpos7_reg <= hpos6_reg;
            disc7_reg <= kneg6_reg ? h2_6_reg + ak6_reg : h2_6_reg - ak6_reg;
            miss7_reg <= zero6_reg || (!kneg6_reg && (ak6_reg > h2_6_reg));
        end
    end

    always_comb begin
        q_item.disc     = disc7_reg;
        q_item.ray.miss = miss7_reg;
        q_item.ray.hpos = hpos7_reg;
        q_item.ray.mh   = mh7_reg;
        q_item.ray.a    = a7_reg;
        q_item.ray.org  = org_reg[7];
        q_item.ray.dir  = dir_reg[7];
    end

endmodule
`default_nettype wire

[rtl/core/rsi_queue.sv]
`default_nettype none
`include "ray_sphere_intersect_assert.svh"
module rsi_queue import rsi_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  rsi_item_t      push_item,
    input  wire logic      pop,
    output rsi_item_t      head,
    output logic           full,
    output logic           empty
);

    localparam int PW = $clog2(Q_DEPTH);

    rsi_item_t     mem_reg [0:Q_DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign full  = cnt_reg == (PW+1)'(Q_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `RSI_ASSERT(a_cnt_range, cnt_reg <= (PW+1)'(Q_DEPTH), "queue count beyond depth")
    `RSI_ASSERT(a_pop_nonempty, pop |-> cnt_reg != '0, "pop from empty queue")
    `RSI_ASSERT_RST(a_rst_empty, !aresetn |=> cnt_reg == '0, "queue not empty after reset")

endmodule
`default_nettype wire

[rtl/core/rsi_back.sv]
`default_nettype none
module rsi_back import rsi_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  rsi_item_t          q_head,
    input  wire logic          q_empty,
    output logic               q_pop,
    input  wire logic [EW-1:0] min_dist,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,
    output logic               m_tuser
);

    logic en;

    // square root, one result bit per stage
    logic [SQ_STEPS-1:0] sq_vld_reg;
    logic [66:0]         sr_reg   [0:SQ_STEPS-1];
    logic [63:0]         sq_reg   [0:SQ_STEPS-1];
    logic [127:0]        sv_reg   [0:SQ_STEPS-1];
    rsi_ray_t            sp_reg   [0:SQ_STEPS-1];
    logic [66:0]         sr_next  [0:SQ_STEPS-1];
    logic [63:0]         sq_next  [0:SQ_STEPS-1];
    logic [127:0]        sv_next  [0:SQ_STEPS-1];

    // root numerators
    logic                r1_vld_reg;
    rsi_ray_t            r1_ray_reg;
    logic [1:0]          r1_neg_reg;
    logic [64:0]         r1_num_reg [0:1];
    logic [NW-1:0]       nsh [0:1];

    logic                r2_vld_reg;
    rsi_ray_t            r2_ray_reg;
    logic [1:0]          r2_neg_reg, r2_ovf_reg;
    logic [63:0]         r2_rem_reg [0:1];
    logic [DW-1:0]       r2_low_reg [0:1];

    // restoring dividers, near root in lane 0 and far root in lane 1
    logic [DV_STEPS-1:0] dv_vld_reg;
    rsi_ray_t            dv_ray_reg [0:DV_STEPS-1];
    logic [1:0]          dv_neg_reg [0:DV_STEPS-1];
    logic [1:0]          dv_ovf_reg [0:DV_STEPS-1];
    logic [63:0]         dv_rem_reg [0:DV_STEPS-1][0:1];
    logic [DW-1:0]       dv_low_reg [0:DV_STEPS-1][0:1];
    logic [DW-1:0]       dv_q_reg   [0:DV_STEPS-1][0:1];
    logic [63:0]         dv_rem_next [0:DV_STEPS-1][0:1];
    logic [DW-1:0]       dv_low_next [0:DV_STEPS-1][0:1];
    logic [DW-1:0]       dv_q_next   [0:DV_STEPS-1][0:1];

    logic [DW-1:0]       tn, tf, t_sel;
    logic                tn_ok, miss_sel;
    logic [2:0][CW-1:0]  dm_sel;

    logic                t_vld_reg, t_miss_reg;
    logic [DW-1:0]       t_reg;
    logic [2:0][CW-1:0]  t_org_reg, t_dir_reg, t_dm_reg;

    logic                h_vld_reg, h_miss_reg;
    logic [DW-1:0]       h_t_reg;
    logic [2:0][CW-1:0]  h_org_reg, h_dir_reg;
    logic [2:0][62:0]    h_m_reg;

    logic [2:0][CW-1:0]  pt;
    logic signed [63:0]  oe, pv;
    logic [63:0]         mr;

    logic                m_tvalid_reg, m_tuser_reg;
    logic [127:0]        m_tdata_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign q_pop    = en && !q_empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            logic [66:0]  r_in, rt;
            logic [63:0]  q_in;
            logic [127:0] v_in;
            logic         ge;
            if (k == 0) begin
                r_in = '0;
                q_in = '0;
                v_in = q_head.disc;
            end else begin
                r_in = sr_reg[k-1];
                q_in = sq_reg[k-1];
                v_in = sv_reg[k-1];
            end
            rt = {r_in[64:0], v_in[127:126]};
            ge = rt >= {1'b0, q_in, 2'b01};
            sr_next[k] = ge ? rt - {1'b0, q_in, 2'b01} : rt;
            sq_next[k] = {q_in[62:0], ge};
            sv_next[k] = {v_in[125:0], 2'b00};
        end
    end

    always_comb begin
        nsh[0] = {r1_num_reg[0], {FRAC_BITS{1'b0}}};
        nsh[1] = {r1_num_reg[1], {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        for (int d = 0; d < DV_STEPS; d++) begin
            for (int l = 0; l < 2; l++) begin
                logic [63:0]   r_in;
                logic [DW-1:0] lo_in, q_in;
                logic [64:0]   rt;
                logic          ge;
                if (d == 0) begin
                    r_in  = r2_rem_reg[l];
                    lo_in = r2_low_reg[l];
                    q_in  = '0;
                end else begin
                    r_in  = dv_rem_reg[d-1][l];
                    lo_in = dv_low_reg[d-1][l];
                    q_in  = dv_q_reg[d-1][l];
                end
                rt = {r_in, lo_in[DW-1]};
                ge = rt >= {1'b0, (d == 0) ? r2_ray_reg.a : dv_ray_reg[d-1].a};
                dv_rem_next[d][l] = ge ? 64'(rt - {1'b0, (d == 0) ? r2_ray_reg.a
                                                               : dv_ray_reg[d-1].a})
                                       : rt[63:0];
                dv_low_next[d][l] = {lo_in[DW-2:0], 1'b0};
                dv_q_next[d][l]   = {q_in[DW-2:0], ge};
            end
        end
    end

    always_comb begin
        tn       = dv_ovf_reg[DV_STEPS-1][0] ? T_MAX : dv_q_reg[DV_STEPS-1][0];
        tf       = dv_ovf_reg[DV_STEPS-1][1] ? T_MAX : dv_q_reg[DV_STEPS-1][1];
        tn_ok    = !dv_neg_reg[DV_STEPS-1][0] && (tn > DW'(min_dist));
        t_sel    = tn_ok ? tn : tf;
        miss_sel = dv_ray_reg[DV_STEPS-1].miss
                   || (!tn_ok && (dv_neg_reg[DV_STEPS-1][1] || (tf < DW'(min_dist))));
        for (int i = 0; i < 3; i++) begin
            dm_sel[i] = dv_ray_reg[DV_STEPS-1].dir[i][CW-1]
                        ? ~dv_ray_reg[DV_STEPS-1].dir[i] + 1'b1
                        : dv_ray_reg[DV_STEPS-1].dir[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            oe = {{(64-CW){h_org_reg[i][CW-1]}}, h_org_reg[i]};
            mr = {1'b0, h_m_reg[i]} + 64'({FRAC_BITS{1'b1}});
            if (h_dir_reg[i][CW-1]) begin
                pv = oe - $signed(mr >> FRAC_BITS);
            end else begin
                pv = oe + $signed({1'b0, h_m_reg[i]} >> FRAC_BITS);
            end
            if (pv > $signed({{(64-CW){1'b0}}, C_MAX})) begin
                pt[i] = C_MAX;
            end else if (pv < $signed({{(64-CW){1'b1}}, C_MIN})) begin
                pt[i] = C_MIN;
            end else begin
                pt[i] = pv[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg   <= '0;
            r1_vld_reg   <= 1'b0;
            r2_vld_reg   <= 1'b0;
            dv_vld_reg   <= '0;
            t_vld_reg    <= 1'b0;
            h_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg   <= {sq_vld_reg[SQ_STEPS-2:0], q_pop};
            r1_vld_reg   <= sq_vld_reg[SQ_STEPS-1];
            r2_vld_reg   <= r1_vld_reg;
            dv_vld_reg   <= {dv_vld_reg[DV_STEPS-2:0], r2_vld_reg};
            t_vld_reg    <= dv_vld_reg[DV_STEPS-1];
            h_vld_reg    <= t_vld_reg;
            m_tvalid_reg <= h_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                sr_reg[k] <= sr_next[k];
                sq_reg[k] <= sq_next[k];
                sv_reg[k] <= sv_next[k];
                sp_reg[k] <= (k == 0) ? q_head.ray : sp_reg[k-1];
            end

            r1_ray_reg <= sp_reg[SQ_STEPS-1];
            if (!sp_reg[SQ_STEPS-1].hpos) begin
                r1_neg_reg[0] <= sp_reg[SQ_STEPS-1].mh < sq_reg[SQ_STEPS-1];
                r1_num_reg[0] <= (sp_reg[SQ_STEPS-1].mh < sq_reg[SQ_STEPS-1]) ? '0
                                 : 65'(sp_reg[SQ_STEPS-1].mh - sq_reg[SQ_STEPS-1]);
                r1_neg_reg[1] <= 1'b0;
                r1_num_reg[1] <= 65'(sp_reg[SQ_STEPS-1].mh) + 65'(sq_reg[SQ_STEPS-1]);
            end else begin
                r1_neg_reg[0] <= 1'b1;
                r1_num_reg[0] <= '0;
                r1_neg_reg[1] <= sq_reg[SQ_STEPS-1] < sp_reg[SQ_STEPS-1].mh;
                r1_num_reg[1] <= (sq_reg[SQ_STEPS-1] < sp_reg[SQ_STEPS-1].mh) ? '0
                                 : 65'(sq_reg[SQ_STEPS-1] - sp_reg[SQ_STEPS-1].mh);
            end

            r2_ray_reg <= r1_ray_reg;
            r2_neg_reg <= r1_neg_reg;
            for (int l = 0; l < 2; l++) begin
                r2_ovf_reg[l] <= 64'(nsh[l][NW-1:DW]) >= r1_ray_reg.a;
                r2_rem_reg[l] <= 64'(nsh[l][NW-1:DW]);
                r2_low_reg[l] <= nsh[l][DW-1:0];
            end

            for (int d = 0; d < DV_STEPS; d++) begin
                dv_ray_reg[d] <= (d == 0) ? r2_ray_reg : dv_ray_reg[d-1];
                dv_neg_reg[d] <= (d == 0) ? r2_neg_reg : dv_neg_reg[d-1];
                dv_ovf_reg[d] <= (d == 0) ? r2_ovf_reg : dv_ovf_reg[d-1];
                for (int l = 0; l < 2; l++) begin
                    dv_rem_reg[d][l] <= dv_rem_next[d][l];
                    dv_low_reg[d][l] <= dv_low_next[d][l];
                    dv_q_reg[d][l]   <= dv_q_next[d][l];
                end
            end

            t_reg      <= t_sel;
            t_miss_reg <= miss_sel;
            t_org_reg  <= dv_ray_reg[DV_STEPS-1].org;
            t_dir_reg  <= dv_ray_reg[DV_STEPS-1].dir;
            t_dm_reg   <= dm_sel;

            h_t_reg    <= t_reg;
            h_miss_reg <= t_miss_reg;
            h_org_reg  <= t_org_reg;
            h_dir_reg  <= t_dir_reg;
            for (int i = 0; i < 3; i++) begin
                h_m_reg[i] <= 63'(t_reg) * 63'(t_dm_reg[i]);
            end

            m_tuser_reg <= !h_miss_reg;
            if (h_miss_reg) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {1'b0, h_t_reg, pt[2], pt[1], pt[0]};
            end
        end
    end

endmodule
`default_nettype wire
